// ----- sv/sha256_byte_stream_hasher_defines.svh -----
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBSH_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBSH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/sbsh_pkg.sv -----
// Types, constants and round functions for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
package sbsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sbsh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sbsh_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_OUT
  } sbsh_state_t;

  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [5:0] PAD_FILL   = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] MARK_BYTE  = 8'h80;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- sv/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte-stream hasher.
// Usage: message bytes arrive on the msg channel (msg_valid / msg_stall), one
// word per handshake; byte_present marks a real byte, end_of_message closes
// the message (with or without a byte, so an empty message works).
// The digest leaves on the dgst channel as eight 32-bit words, most
// significant first, last_word set on the eighth.
// Throughput: a byte is taken every cycle while the block buffer fills; the
// 64th byte of a block starts a compression (64 rounds on the single round
// unit, then a fold into the chaining words) before the next byte is taken.
// End of message: padding is pushed one byte per cycle outside compressions,
// with a pause when the zeros reach the length field, and takes one or two
// compressions before the first digest word appears.
// msg_stall is high whenever the block is padding, compressing or emitting.
// A stall on dgst holds the current digest word; the block waits for it.
// Reset (rst, synchronous) loads the initial hash, clears the fill count and
// bit length, and returns to idle; a new message starts after each digest.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sbsh_pkg::sbsh_in_t    msg,
  output logic                  dgst_valid,
  input  logic                  dgst_stall,
  output sbsh_pkg::sbsh_out_t   dgst
);
  import sbsh_pkg::*;

  sbsh_state_t state, state_next;
  sbsh_state_t resume, resume_next;

  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [31:0]  v_next [8];
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bit_length;
  logic [5:0]   rnd;
  logic [2:0]   widx;

  logic       msg_take;
  logic       dgst_take;
  logic       push;
  logic [7:0] push_byte;
  logic       go_comp;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, choose, major;
  logic [7:0]  len_byte;

  assign msg_stall  = (state != S_IDLE);
  assign dgst_valid = (state == S_OUT);
  assign msg_take   = msg_valid && !msg_stall;
  assign dgst_take  = dgst_valid && !dgst_stall;

  assign dgst.digest_word = chain[widx];
  assign dgst.word_index  = widx;
  assign dgst.last_word   = (widx == LAST_WORD);

  // Length bytes go out big-endian while fill runs from 56 to 63.
  assign len_byte = bit_length[{3'd7 - fill[2:0], 3'b000} +: 8];

  // Schedule window: word 0 is the current round's word.
  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + big_sigma1(v[4]) + choose + ROUND_K[rnd] + w0;
  assign t2     = big_sigma0(v[0]) + major;

  always_comb begin
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= S_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  always_comb begin
    state_next  = state;
    resume_next = resume;
    push        = 1'b0;
    push_byte   = 8'h00;
    case (state)
      S_IDLE: begin
        if (msg_take) begin
          if (msg.byte_present) begin
            push      = 1'b1;
            push_byte = msg.data_byte;
          end
          if (msg.byte_present && fill == LAST_FILL) begin
            state_next  = S_ROUND;
            resume_next = msg.end_of_message ? S_MARK : S_IDLE;
          end else if (msg.end_of_message) begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        push      = 1'b1;
        push_byte = MARK_BYTE;
        state_next = S_ZERO;
        if (fill == LAST_FILL) begin
          state_next  = S_ROUND;
          resume_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill == PAD_FILL) begin
          state_next = S_LEN;
        end else begin
          push = 1'b1;
          if (fill == LAST_FILL) begin
            state_next  = S_ROUND;
            resume_next = S_ZERO;
          end
        end
      end
      S_LEN: begin
        push      = 1'b1;
        push_byte = len_byte;
        if (fill == LAST_FILL) begin
          state_next  = S_ROUND;
          resume_next = S_OUT;
        end
      end
      S_ROUND: begin
        if (rnd == LAST_ROUND) state_next = S_FOLD;
      end
      S_FOLD: begin
        state_next = resume;
      end
      S_OUT: begin
        if (dgst_take && widx == LAST_WORD) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign go_comp = (state_next == S_ROUND) && (state != S_ROUND);

  always_ff @(posedge clk) begin
    if (push) blk <= {blk[503:0], push_byte};
    if (state == S_ROUND) blk <= {blk[479:0], w_new};
    if (go_comp) begin
      v <= chain;
    end else if (state == S_ROUND) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= INITIAL_H;
      fill       <= '0;
      bit_length <= '0;
      rnd        <= '0;
      widx       <= '0;
    end else begin
      if (push) fill <= fill + 6'd1;
      if (msg_take && msg.byte_present) bit_length <= bit_length + BYTE_BITS;
      if (go_comp) begin
        rnd <= '0;
      end else if (state == S_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == S_FOLD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
      if (dgst_take) begin
        widx <= widx + 3'd1;
        // Start the next message from the initial hash.
        if (widx == LAST_WORD) begin
          chain      <= INITIAL_H;
          fill       <= '0;
          bit_length <= '0;
        end
      end
    end
  end

  `SBSH_ASSERT_NOW(a_no_overlap, !msg_stall, !dgst_valid, "input taken while digest pending")
  `SBSH_ASSERT_NOW(a_empty_in_rounds, state == S_ROUND, fill == 6'd0, "buffer not empty in rounds")
  `SBSH_ASSERT_NEXT(a_round_end, state == S_ROUND && rnd == LAST_ROUND,
                    state == S_FOLD, "fold missed")
  `SBSH_ASSERT_NEXT(a_fresh_msg, dgst_take && dgst.last_word,
                    state == S_IDLE && fill == 6'd0 && bit_length == 64'd0, "state not cleared")

endmodule

// ----- tb/tb_sha256_byte_stream_hasher.sv -----
// Self-checking testbench for the SHA-256 byte-stream hasher: queued messages in, digests checked.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;
  import sbsh_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_WORDS  = 42;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_stall;
  sbsh_in_t  msg = '0;
  logic      dgst_valid;
  logic      dgst_stall = 1'b0;
  sbsh_out_t dgst;

  sbsh_in_t  msg_words [$];
  sbsh_out_t expected_digest [$];

  // hash state tracked alongside the block
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  logic        msg_taken = 1'b0;
  int unsigned words_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  idle_mode_t  idle_mode;

  always #6 clk = ~clk;

  sha256_byte_stream_hasher DUT (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg),
    .dgst_valid (dgst_valid),
    .dgst_stall (dgst_stall),
    .dgst       (dgst)
  );

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_restart();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void sha_push_byte(input logic [7:0] value);
    blk_bytes[blk_fill] = value;
    blk_fill++;
    if (blk_fill == 64) begin
      sha_compress();
      blk_fill = 0;
    end
  endfunction

  // Fold one accepted word into the hash; on end of message queue the digest.
  function automatic void sha_absorb_word(input sbsh_in_t word);
    logic [63:0] length_bits;
    sbsh_out_t   result;
    if (word.byte_present) begin
      sha_push_byte(word.data_byte);
      msg_bits += 64'd8;
    end
    if (word.end_of_message) begin
      length_bits = msg_bits;
      sha_push_byte(8'h80);
      while (blk_fill != 56) sha_push_byte(8'h00);
      for (int i = 0; i < 8; i++) sha_push_byte(length_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        result.digest_word = chain_h[i];
        result.word_index  = 3'(i);
        result.last_word   = (i == 7);
        expected_digest.push_back(result);
      end
      sha_restart();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] digest error, %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  function automatic void queue_word(input logic [7:0] value, input logic present,
                                     input logic ends);
    sbsh_in_t word;
    word.data_byte      = value;
    word.byte_present   = present;
    word.end_of_message = ends;
    msg_words.push_back(word);
  endfunction

  // Returns the number of words queued, noise included.
  function automatic int queue_message(input int len, input bit end_on_byte);
    int count;
    count = 0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) begin
        queue_word(8'($urandom()), 1'b0, 1'b0);
        count++;
      end
      queue_word(8'($urandom()), 1'b1, end_on_byte && (k == len - 1));
      count++;
    end
    if (!end_on_byte || len == 0) begin
      queue_word(8'($urandom()), 1'b0, 1'b1);
      count++;
    end
    return count;
  endfunction

  assign idle_mode = idle_mode_t'((words_taken / PHASE_WORDS) % 4);

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 47;
      IDLE_BOTH:   return $urandom_range(99) < 13;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 47;
      IDLE_BOTH:     return $urandom_range(99) < 13;
      default:       return 1'b0;
    endcase
  endfunction

  // driver: advance on acceptance, otherwise hold the word
  always @(negedge clk) begin
    if (!rst) begin
      if (!msg_valid || msg_taken) begin
        if (msg_words.size() != 0 && !sender_idle()) begin
          msg       <= msg_words.pop_front();
          msg_valid <= 1'b1;
        end else begin
          msg_valid <= 1'b0;
        end
      end
      dgst_stall <= receiver_stall();
    end
  end

  // monitor
  always @(posedge clk) begin
    sbsh_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      msg_taken <= msg_valid && !msg_stall;
      if (dgst_valid && !dgst_stall) begin
        if (expected_digest.size() == 0) begin
          report_mismatch("unexpected word", '0, dgst.digest_word);
        end else begin
          want = expected_digest.pop_front();
          if (dgst.digest_word !== want.digest_word)
            report_mismatch("digest_word", want.digest_word, dgst.digest_word);
          if (dgst.word_index !== want.word_index)
            report_mismatch("word_index", 32'(want.word_index), 32'(dgst.word_index));
          if (dgst.last_word !== want.last_word)
            report_mismatch("last_word", 32'(want.last_word), 32'(dgst.last_word));
        end
      end
      if (msg_valid && !msg_stall) begin
        sha_absorb_word(msg);
        words_taken++;
      end
    end
  end

  initial begin
    int batch;
    int long_lens [2];
    sha_restart();
    long_lens = '{64, 56};

    // directed: ignored words, empty message, byte with end, separate end
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hff, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(8'hff, 1'b1, 1'b1);
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'hff, 1'b0, 1'b1);
    queue_word(8'h61, 1'b1, 1'b0);
    queue_word(8'h62, 1'b1, 1'b0);
    queue_word(8'h63, 1'b1, 1'b1);
    queue_word(8'h80, 1'b1, 1'b0);
    queue_word(8'h7f, 1'b1, 1'b0);
    queue_word(8'h55, 1'b0, 1'b0);
    queue_word(8'haa, 1'b0, 1'b1);

    // random: short messages, then a full block and a padding spill into a second block
    foreach (long_lens[j]) begin
      batch = 0;
      while (batch < 6) batch += queue_message($urandom_range(0, 12), $urandom_range(1));
      void'(queue_message(long_lens[j], $urandom_range(1)));
    end
    batch = 0;
    while (batch < 6) batch += queue_message($urandom_range(0, 12), $urandom_range(1));

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (msg_words.size() != 0 || msg_valid) @(posedge clk);
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sha256_byte_stream_hasher.f -----
+incdir+sv
sv/sbsh_pkg.sv
sv/sha256_byte_stream_hasher.sv
tb/tb_sha256_byte_stream_hasher.sv
